>>> hw/rtl/gsk_pkg.sv
// Shared types and constants for the grouped-sum engine.
// No dependencies; imported by the top level, the checker and the testbench.
package gsk_pkg;

    // Store geometry
    localparam int MAX_GROUPS = 1024;
    localparam int ADDR_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SUM_W      = 64;
    localparam int CFG_W      = 11;

    // Group count as a 32-bit key bound
    localparam logic [31:0] MAX_GROUPS_KEY = 32'(MAX_GROUPS);

    // Reset value of the group count register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    // Item operation codes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ACCUM = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        group_id;
        logic signed [31:0] value;
    } gsk_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] group_sum;
        logic                    in_range;
    } gsk_out_t;

endpackage

>>> hw/rtl/gsk_sum_ram.sv
// Simple dual-port synchronous RAM holding the per-group sums.
// One write port, one registered read port (read-before-write on a collision).
module gsk_sum_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/group_sum_by_key_unit.sv
// Top level of the grouped-sum engine: command decode, read-modify-write
// pipeline with forwarding, clear sweep. Uses gsk_pkg and gsk_sum_ram.
//
// Accumulate and read items are taken one per clock while busy is low: each
// reads its group's sum from the store RAM, and an accumulate writes the new
// sum back in the next cycle; a write landing on the same entry as the next
// item's read is forwarded, so back-to-back updates of one group are exact. A
// read's answer passes through the stage 1 and result registers to the result
// ports. A clear walks the whole store through the RAM's single write port,
// one entry per cycle, so busy stays high until all MAX_GROUPS (1024) entries
// are zeroed; its answer (sum 0, in_range 0) appears in the cycle busy falls.
// The same sweep runs once after reset to zero the store: busy is high from
// reset until that sweep ends, and it gives no answer. Results are shown for
// one cycle only and cannot be held off. The group count register may be
// written only while the engine is idle; its write channel is always ready.
module group_sum_by_key_unit
    import gsk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  gsk_in_t          in_item,
    output logic             result_valid,
    output gsk_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S1_NONE,
        S1_ACC,
        S1_READ
    } s1_kind_t;

    logic                    accept;
    logic                    id_ok;

    logic [CFG_W-1:0]        groups_reg;
    logic                    clear_reg;
    logic                    clear_next;
    logic                    init_reg;
    logic [ADDR_W-1:0]       sweep_reg;
    logic [ADDR_W-1:0]       sweep_next;
    logic                    sweep_last;

    s1_kind_t                s1_kind_reg;
    s1_kind_t                s1_kind_next;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic signed [31:0]      s1_value_reg;
    logic                    s1_ok_reg;
    logic                    fwd_hit_reg;
    logic [SUM_W-1:0]        fwd_data_reg;

    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [SUM_W-1:0]        wdata;
    logic [ADDR_W-1:0]       raddr;
    logic [SUM_W-1:0]        rdata;
    logic [SUM_W-1:0]        base;

    logic                    result_valid_reg;
    logic                    result_valid_next;
    gsk_out_t                result_reg;

    // handshake
    assign busy      = clear_reg;
    assign accept    = start & ~clear_reg;
    assign cfg_ready = 1'b1;
    assign raddr     = in_item.group_id[ADDR_W-1:0];

    // id check against both the configured count and the store size
    assign id_ok = (in_item.group_id < {{(32-CFG_W){1'b0}}, groups_reg})
                 && (in_item.group_id < MAX_GROUPS_KEY);

    // group count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            groups_reg <= cfg_data;
        end
    end

    // clear sweep control
    assign sweep_last = clear_reg && (sweep_reg == ADDR_W'(MAX_GROUPS - 1));

    always_comb
    begin
        clear_next = clear_reg;
        sweep_next = sweep_reg;
        if (clear_reg)
        begin
            sweep_next = sweep_reg + 1'b1;
            if (sweep_last)
            begin
                clear_next = 1'b0;
            end
        end
        else if (accept && (in_item.mode == MODE_CLEAR))
        begin
            clear_next = 1'b1;
            sweep_next = '0;
        end
    end

    // stage 1 operation for the item just taken
    always_comb
    begin
        s1_kind_next = S1_NONE;
        if (accept)
        begin
            case (in_item.mode)
                MODE_ACCUM: s1_kind_next = id_ok ? S1_ACC : S1_NONE;
                MODE_READ:  s1_kind_next = S1_READ;
                default:    s1_kind_next = S1_NONE;
            endcase
        end
    end

    // forwarded or stored sum of the stage 1 entry
    assign base = fwd_hit_reg ? fwd_data_reg : rdata;

    // single write port: sweep or accumulate write-back
    always_comb
    begin
        we    = 1'b0;
        waddr = s1_addr_reg;
        wdata = base + {{(SUM_W-32){s1_value_reg[31]}}, s1_value_reg};
        if (clear_reg)
        begin
            we    = 1'b1;
            waddr = sweep_reg;
            wdata = '0;
        end
        else if (s1_kind_reg == S1_ACC)
        begin
            we = 1'b1;
        end
    end

    gsk_sum_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    // result strobe: read answer or end of a clear item's sweep
    assign result_valid_next = (s1_kind_reg == S1_READ) || (sweep_last && !init_reg);

    // control registers; the sweep starts at reset to zero the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg        <= 1'b1;
            init_reg         <= 1'b1;
            sweep_reg        <= '0;
            s1_kind_reg      <= S1_NONE;
            fwd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg        <= clear_next;
            init_reg         <= init_reg && !sweep_last;
            sweep_reg        <= sweep_next;
            s1_kind_reg      <= s1_kind_next;
            fwd_hit_reg      <= accept && we && (waddr == raddr);
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= raddr;
            s1_value_reg <= in_item.value;
            s1_ok_reg    <= id_ok;
            fwd_data_reg <= wdata;
        end
        if (s1_kind_reg == S1_READ)
        begin
            result_reg.group_sum <= s1_ok_reg ? base : '0;
            result_reg.in_range  <= s1_ok_reg;
        end
        else if (sweep_last)
        begin
            result_reg.group_sum <= '0;
            result_reg.in_range  <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/gsk_checker.sv
// Port-level checks for the grouped-sum engine, bound to the top level.
// Uses gsk_pkg for the item codes and payload types.
module gsk_checker
    import gsk_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input gsk_in_t  in_item,
    input logic     result_valid,
    input gsk_out_t result
);

    logic taken;
    logic sweep_seen_reg;
    assign taken = start && !busy;

    // busy is first high for the silent store sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_seen_reg <= 1'b0;
        end
        else if (!busy)
        begin
            sweep_seen_reg <= 1'b1;
        end
    end

    // a clear item holds off new items on the next cycle
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && (in_item.mode == MODE_CLEAR)) |=> busy)
        else $error("clear item did not raise busy");

    // end of a clear sweep comes with its answer
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_seen_reg && $fell(busy))
            |-> (result_valid && !result.in_range && (result.group_sum == '0)))
        else $error("clear answer missing when busy fell");

    // a read answers once it has passed stage 1 and the result register
    a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && (in_item.mode == MODE_READ)) |-> ##2 result_valid)
        else $error("read item gave no answer");

    // an accumulate item never answers
    a_accum_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && (in_item.mode == MODE_ACCUM)) |-> ##2 !result_valid)
        else $error("accumulate item gave an answer");

    // an out-of-range answer carries a zero sum
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.in_range) |-> (result.group_sum == '0))
        else $error("out-of-range answer with nonzero sum");

endmodule

bind group_sum_by_key_unit gsk_checker u_gsk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .result_valid (result_valid),
    .result       (result)
);

>>> dv/tb_top.sv
// Self-checking testbench for group_sum_by_key_unit: directed and random items
// checked against an in-bench model of the per-group sum store.
// Depends on gsk_pkg and the RTL of the grouped-sum engine.
`timescale 1ns / 100ps

module tb_top;
    import gsk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // a clear alone holds busy while it sweeps all MAX_GROUPS entries
    localparam int PIPE_SETTLE    = 6;     // lets a read's answer and an accumulate's write-back finish

    // Spare operation code with no effect
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    gsk_in_t          in_item;
    logic             result_valid;
    gsk_out_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Bench copy of the engine state
    logic [SUM_W-1:0] group_sums [MAX_GROUPS];
    logic [CFG_W-1:0] group_count;
    gsk_out_t         pending_sums[$];

    int idle_pct;
    int mismatch_count;
    int quiet_cycles;

    group_sum_by_key_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Effective number of valid ids
    function automatic logic [31:0] active_groups();
        if (group_count > CFG_W'(MAX_GROUPS))
            return MAX_GROUPS_KEY;
        return 32'(group_count);
    endfunction

    // Update the bench store for one accepted item, queue its answer if any
    task automatic predict_item(input gsk_in_t it);
        gsk_out_t ans;
        logic     hit;
        hit = it.group_id < active_groups();
        ans = '0;
        case (it.mode)
            MODE_CLEAR:
            begin
                foreach (group_sums[i])
                    group_sums[i] = '0;
                pending_sums.push_back(ans);
            end
            MODE_ACCUM:
            begin
                if (hit)
                    group_sums[it.group_id[ADDR_W-1:0]] += {{32{it.value[31]}}, it.value};
            end
            MODE_READ:
            begin
                if (hit)
                begin
                    ans.group_sum = group_sums[it.group_id[ADDR_W-1:0]];
                    ans.in_range  = 1'b1;
                end
                pending_sums.push_back(ans);
            end
            default: ;  // unused code: no effect
        endcase
    endtask

    // Present one item, hold it until taken, then predict
    task automatic send_item(input logic [1:0] mode, input logic [31:0] gid,
                             input logic [31:0] val);
        gsk_in_t it;
        it.mode     = mode;
        it.group_id = gid;
        it.value    = val;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_item(it);
    endtask

    // Stop sending and let every expected answer come back
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Write the group count register while the engine is idle
    task automatic write_group_count(input logic [CFG_W-1:0] n);
        wait_for_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        group_count = n;
    endtask

    // Random id: hot groups, ids in use, the limit edge, or any 32-bit key
    function automatic logic [31:0] pick_group();
        int unsigned r;
        logic [31:0] lim;
        r   = $urandom_range(0, 99);
        lim = active_groups();
        if (r < 45)
            return 32'($urandom_range(0, 7));
        if (r < 75)
            return (lim == 0) ? 32'd0 : 32'($urandom_range(0, lim - 1));
        if (r < 90)
            return lim + 32'($urandom_range(0, 2)) - 32'd1;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (r < 20)
            return 32'($signed($urandom_range(0, 20)) - 10);
        return $urandom;
    endfunction

    task automatic send_random_item();
        int unsigned r;
        logic [1:0]  mode;
        r = $urandom_range(0, 199);
        if (r < 3)
            mode = MODE_SPARE;
        else if (r < 5)
            mode = MODE_CLEAR;
        else if (r < 70)
            mode = MODE_READ;
        else
            mode = MODE_ACCUM;
        send_item(mode, pick_group(), pick_value());
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin
        gsk_out_t want;
        if (result_valid === 1'b1)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t unexpected result: group_sum %0d in_range %0b",
                         $time, result.group_sum, result.in_range);
                mismatch_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (result.group_sum !== want.group_sum)
                begin
                    $display("%0t group_sum mismatch: expected %0d actual %0d",
                             $time, want.group_sum, result.group_sum);
                    mismatch_count++;
                end
                if (result.in_range !== want.in_range)
                begin
                    $display("%0t in_range mismatch: expected %0b actual %0b",
                             $time, want.in_range, result.in_range);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no item, result or register write taken
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog expired, %0d answers outstanding",
                     $time, pending_sums.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Fresh store reads as zero, out-of-range reads answer zero
    task automatic test_reset_state();
        idle_pct = 0;
        send_item(MODE_READ, 32'd0, 32'd0);
        send_item(MODE_READ, 32'd1023, 32'd0);
        send_item(MODE_READ, 32'd1024, 32'd0);
        send_item(MODE_READ, 32'hFFFF_FFFF, 32'd0);
    endtask

    // Value and id extremes, every operation, ignored ids, unused mode, clear
    task automatic test_field_extremes();
        idle_pct = 0;
        send_item(MODE_ACCUM, 32'd0, 32'h7FFF_FFFF);
        send_item(MODE_ACCUM, 32'd0, 32'h7FFF_FFFF);
        send_item(MODE_READ, 32'd0, 32'd0);
        send_item(MODE_ACCUM, 32'd1023, 32'h8000_0000);
        send_item(MODE_ACCUM, 32'd1023, 32'hFFFF_FFFF);
        send_item(MODE_READ, 32'd1023, 32'hFFFF_FFFF);
        send_item(MODE_ACCUM, 32'd1024, 32'h1234_5678);       // ignored id
        send_item(MODE_ACCUM, 32'hFFFF_FFFF, 32'h7FFF_FFFF);  // ignored id
        send_item(MODE_READ, 32'hFFFF_FFFF, 32'd0);
        send_item(MODE_SPARE, 32'd0, 32'h7FFF_FFFF);          // unused code
        send_item(MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_READ, 32'd0, 32'd0);
        send_item(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_READ, 32'd0, 32'd0);
        send_item(MODE_READ, 32'd1023, 32'd0);
        send_item(MODE_ACCUM, 32'd5, 32'd1);
        send_item(MODE_ACCUM, 32'd5, 32'hFFFF_FFFE);
        send_item(MODE_READ, 32'd5, 32'd0);
        send_item(MODE_CLEAR, 32'd0, 32'd0);
    endtask

    // Group count at zero, one and above the store size; entries past the
    // limit still get zeroed by a clear
    task automatic test_group_limits();
        idle_pct = 0;
        send_item(MODE_ACCUM, 32'd900, 32'd77);
        write_group_count(CFG_W'(0));
        send_item(MODE_ACCUM, 32'd0, 32'd9);
        send_item(MODE_READ, 32'd0, 32'd0);
        write_group_count(CFG_W'(1));
        send_item(MODE_ACCUM, 32'd0, 32'd9);
        send_item(MODE_ACCUM, 32'd1, 32'd9);
        send_item(MODE_READ, 32'd0, 32'd0);
        send_item(MODE_READ, 32'd1, 32'd0);
        send_item(MODE_CLEAR, 32'd0, 32'd0);
        write_group_count(CFG_W'(2047));
        send_item(MODE_READ, 32'd900, 32'd0);
        send_item(MODE_ACCUM, 32'd1023, 32'd3);
        send_item(MODE_READ, 32'd1023, 32'd0);
        send_item(MODE_READ, 32'd1024, 32'd0);
        write_group_count(CFG_W'(1025));
        send_item(MODE_READ, 32'd1024, 32'd0);
        send_item(MODE_READ, 32'd1023, 32'd0);
    endtask

    // Random traffic under one group count and one sender idle rate;
    // halfway through, the sender waits for every answer once
    task automatic test_random_traffic(input logic [CFG_W-1:0] count, input int pct,
                                       input int n_items);
        write_group_count(count);
        idle_pct = pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                wait_for_quiet();
            send_random_item();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        in_item        <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_pct       = 0;
        group_count    = CFG_RESET;
        foreach (group_sums[i])
            group_sums[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_group_limits();
        test_random_traffic(CFG_W'(1024), 0, 470);
        test_random_traffic(CFG_W'(37), 69, 470);
        test_random_traffic(CFG_W'(2047), 0, 470);
        test_random_traffic(CFG_W'($urandom_range(1, 1023)), 16, 470);

        wait_for_quiet();
        repeat (PIPE_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> group_sum_by_key_unit.f
hw/rtl/gsk_pkg.sv
hw/rtl/gsk_sum_ram.sv
hw/rtl/group_sum_by_key_unit.sv
hw/rtl/gsk_checker.sv
dv/tb_top.sv
